// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PNC_ASSERT_CLK(clk, rst_n, lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the module clock clk_i and reset rst_ni.
`define PNC_ASSERT(lbl, prop, msg) \
  `PNC_ASSERT_CLK(clk_i, rst_ni, lbl, prop, msg)

`endif

// ----- hw/rtl/pnc_pkg.sv -----
package pnc_pkg;

  localparam int unsigned PERIOD_W       = 24;
  localparam int unsigned FREQ_W         = 24;
  localparam int unsigned TOL_W          = 14;
  localparam int unsigned NOTE_CNT       = 8;
  localparam int unsigned NOTE_IDX_W     = 3;
  localparam int unsigned NOTE_W         = 14;
  localparam int unsigned IN_TDATA_W     = 24;
  localparam int unsigned OUT_TDATA_W    = 32;
  localparam int unsigned WINDOW_LEN_DEF = 5;

  localparam logic [TOL_W-1:0]  TOL_RST     = 14'd240;
  localparam logic [FREQ_W-1:0] FREQ_NUM_Q4 = 24'd16000000;

  // C4 .. C5 in Q.4 Hz
  localparam logic [NOTE_W-1:0] NOTE_Q4 [NOTE_CNT] = '{
    14'd4186, 14'd4699, 14'd5274, 14'd5588,
    14'd6272, 14'd7040, 14'd7902, 14'd8372
  };

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic [NOTE_IDX_W-1:0] note;
    logic [FREQ_W-1:0]     diff;
  } match_res_t;

endpackage

// ----- hw/rtl/pitch_note_classifier.sv -----
// Channel   Direction  Payload (low bit up)
// s_axis    in         tdata[23:0] period_us
// m_axis    out        tdata[23:0] avg_freq_q4, [26:24] nearest_note,
//                      [27] in_tolerance, [28] announce
// cfg       in         cfg_wdata_i[13:0] tolerance_q4, written when cfg_we_i
//
// An item with a nonzero period takes two passes of the bit-serial divider
// (period to frequency, then the average) and a nearest-note search over the
// eight notes, with hand-over between the steps, before the next input is
// taken. A zero period is accepted and yields no result.
// s_axis_tready is high only while no item is in work; a result waiting on
// m_axis does not block the next input, only the next result.
// Reset empties the ring, clears the last announced note and sets tolerance
// to 240.
`include "assert_macros.svh"

module pitch_note_classifier import pnc_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TOL_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [23:0] period_us
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // avg, note, in_tol, announce
);

  localparam int unsigned DVD_W = FREQ_W + $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREQ,
    ST_SUM,
    ST_AVG,
    ST_SRCH,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [TOL_W-1:0]      tol_q;
  logic                  last_valid_q;
  logic [NOTE_IDX_W-1:0] last_note_q;
  logic                  out_valid_q, out_tol_q, out_ann_q;
  logic [NOTE_IDX_W-1:0] out_note_q;
  logic [FREQ_W-1:0]     avg_q;

  logic                  in_acc, start_freq, div_start, ring_wr, match_start, out_load;
  logic                  in_tol, ann;
  logic [DVD_W-1:0]      div_dvd, quo;
  logic [FREQ_W-1:0]     div_dvs;
  logic [DVD_W-1:0]      ring_sum;
  logic [CNT_W-1:0]      ring_cnt;
  unit_stat_t            div_stat, match_stat;
  match_res_t            match_res;

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign start_freq    = in_acc && (s_axis_tdata[PERIOD_W-1:0] != '0);
  assign div_start     = start_freq || (state_q == ST_SUM);
  assign div_dvd       = (state_q == ST_SUM) ? ring_sum : DVD_W'(FREQ_NUM_Q4);
  assign div_dvs       = (state_q == ST_SUM) ? FREQ_W'(ring_cnt)
                                             : s_axis_tdata[PERIOD_W-1:0];
  assign ring_wr       = (state_q == ST_FREQ) && div_stat.done;
  assign match_start   = (state_q == ST_AVG) && div_stat.done;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign in_tol = match_res.diff < FREQ_W'(tol_q);
  assign ann    = in_tol && (!last_valid_q || (last_note_q != match_res.note));

  pnc_div #(
    .DVD_W(DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (quo),
    .stat_o     (div_stat)
  );

  pnc_ring #(
    .WINDOW_LEN(WINDOW_LEN),
    .SUM_W     (DVD_W),
    .CNT_W     (CNT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_acc),
    .wr_en_i (ring_wr),
    .freq_i  (quo[FREQ_W-1:0]),
    .sum_o   (ring_sum),
    .count_o (ring_cnt)
  );

  pnc_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (match_start),
    .avg_i   (quo[FREQ_W-1:0]),
    .res_o   (match_res),
    .stat_o  (match_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tol_q        <= TOL_RST;
      last_valid_q <= 1'b0;
      last_note_q  <= '0;
      out_valid_q  <= 1'b0;
      out_tol_q    <= 1'b0;
      out_ann_q    <= 1'b0;
      out_note_q   <= '0;
      avg_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_freq) begin
            state_q <= ST_FREQ;
          end
        end
        ST_FREQ: begin
          if (div_stat.done) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          state_q <= ST_AVG;
        end
        ST_AVG: begin
          if (div_stat.done) begin
            state_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (match_stat.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            avg_q       <= quo[FREQ_W-1:0];
            out_tol_q   <= in_tol;
            out_ann_q   <= ann;
            out_note_q  <= match_res.note;
            if (ann) begin
              last_valid_q <= 1'b1;
              last_note_q  <= match_res.note;
            end
            if (!in_tol) begin
              last_valid_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_ann_q, out_tol_q, out_note_q, avg_q};

  `PNC_ASSERT(a_ann_in_tol, out_valid_q && out_ann_q |-> out_tol_q, "announce without tolerance")
  `PNC_ASSERT(a_ann_kept, out_load && ann |=> last_valid_q && last_note_q == out_note_q, "note lost")
  `PNC_ASSERT(a_search_idle, match_stat.busy |-> !div_stat.busy, "search overlaps division")

endmodule

// ----- hw/rtl/pnc_div.sv -----
`include "assert_macros.svh"

module pnc_div import pnc_pkg::*; #(
  parameter int unsigned DVD_W = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [FREQ_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output unit_stat_t       stat_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic [FREQ_W-1:0] rem_q, div_q, rem_d;
  logic [DVD_W-1:0]  quo_q;
  logic              busy_q, done_q;
  logic [FREQ_W:0]   trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
        rem_q  <= '0;
        div_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DVD_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `PNC_ASSERT(a_div_no_restart, busy_q |-> !start_i, "divider restarted while busy")
  `PNC_ASSERT(a_div_rem_bound, busy_q |-> rem_q < div_q, "partial remainder not below divisor")

endmodule

// ----- hw/rtl/pnc_ring.sv -----
module pnc_ring import pnc_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int unsigned SUM_W      = 27,
  parameter int unsigned CNT_W      = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic              wr_en_i,
  input  logic [FREQ_W-1:0] freq_i,
  output logic [SUM_W-1:0]  sum_o,
  output logic [CNT_W-1:0]  count_o
);

  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  logic [FREQ_W-1:0] hist_q [WINDOW_LEN];
  logic [FREQ_W-1:0] old_q;
  logic [SLOT_W-1:0] slot_q;
  logic              full_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              last_slot;

  assign last_slot = slot_q == SLOT_W'(WINDOW_LEN - 1);
  assign sum_d     = sum_q + SUM_W'(freq_i) - (full_q ? SUM_W'(old_q) : '0);

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      old_q <= hist_q[slot_q];
    end
    if (wr_en_i) begin
      hist_q[slot_q] <= freq_i;
    end
  end

  // running sum: drop the overwritten entry once the ring has wrapped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else if (wr_en_i) begin
      sum_q  <= sum_d;
      slot_q <= last_slot ? '0 : slot_q + 1'b1;
      full_q <= full_q | last_slot;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = full_q ? CNT_W'(WINDOW_LEN) : CNT_W'(slot_q);

endmodule

// ----- hw/rtl/pnc_match.sv -----
module pnc_match import pnc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FREQ_W-1:0] avg_i,
  output match_res_t        res_o,
  output unit_stat_t        stat_o
);

  logic [FREQ_W-1:0]     avg_q, bdiff_q, note_f, d;
  logic [NOTE_IDX_W-1:0] idx_q, best_q;
  logic                  busy_q, done_q;

  always_comb begin
    note_f = FREQ_W'(NOTE_Q4[idx_q]);
    d      = (avg_q >= note_f) ? avg_q - note_f : note_f - avg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      best_q  <= '0;
      bdiff_q <= '0;
      avg_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        avg_q   <= avg_i;
        idx_q   <= '0;
        best_q  <= '0;
        bdiff_q <= '1;
      end else if (busy_q) begin
        // strict compare keeps the lower index on a tie
        if (d < bdiff_q) begin
          bdiff_q <= d;
          best_q  <= idx_q;
        end
        idx_q <= idx_q + 1'b1;
        if (idx_q == NOTE_IDX_W'(NOTE_CNT - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.note  = best_q;
  assign res_o.diff  = bdiff_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- test/note_stream_checker.sv -----
`timescale 1ns / 1ps

module note_stream_checker import pnc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TOL_W-1:0]       cfg_wdata_i,
  input  logic                   s_valid_i,
  input  logic                   s_ready_i,
  input  logic [IN_TDATA_W-1:0]  s_data_i,
  input  logic                   m_valid_i,
  input  logic                   m_ready_i,
  input  logic [OUT_TDATA_W-1:0] m_data_i,
  output int                     mismatch_count_o,
  output int                     results_due_o
);

  typedef struct packed {
    logic [FREQ_W-1:0]     avg;
    logic [NOTE_IDX_W-1:0] note;
    logic                  in_tol;
    logic                  announce;
  } note_result_t;

  note_result_t          note_results_due [$];
  logic [FREQ_W-1:0]     freq_ring [WINDOW_LEN_DEF];
  int unsigned           ring_slot;
  logic                  ring_wrapped;
  logic                  held_valid;
  logic [NOTE_IDX_W-1:0] held_note;
  logic [TOL_W-1:0]      tolerance;

  task automatic classify_period(input logic [PERIOD_W-1:0] period, output note_result_t res);
    logic [31:0]       sum;
    int unsigned       count;
    int unsigned       best;
    int unsigned       best_diff;
    int unsigned       diff;
    int                i;
    logic [FREQ_W-1:0] avg;
    freq_ring[ring_slot] = FREQ_W'(32'(FREQ_NUM_Q4) / 32'(period));
    ring_slot++;
    if (ring_slot == WINDOW_LEN_DEF) begin
      ring_slot    = 0;
      ring_wrapped = 1'b1;
    end
    count = ring_wrapped ? WINDOW_LEN_DEF : ring_slot;
    sum = '0;
    for (i = 0; i < count; i++) begin
      sum += freq_ring[i];
    end
    avg = FREQ_W'(sum / count);
    best      = 0;
    best_diff = '1;
    for (i = 0; i < NOTE_CNT; i++) begin
      diff = (avg >= NOTE_Q4[i]) ? avg - NOTE_Q4[i] : NOTE_Q4[i] - avg;
      if (diff < best_diff) begin
        best_diff = diff;
        best      = i;
      end
    end
    res.avg      = avg;
    res.note     = NOTE_IDX_W'(best);
    res.in_tol   = best_diff < tolerance;
    res.announce = res.in_tol && (!held_valid || held_note != res.note);
    if (res.announce) begin
      held_valid = 1'b1;
      held_note  = res.note;
    end
    if (!res.in_tol) begin
      held_valid = 1'b0;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    note_result_t due;
    if (!rst_ni) begin
      ring_slot        = 0;
      ring_wrapped     = 1'b0;
      held_valid       = 1'b0;
      held_note        = '0;
      tolerance        = TOL_RST;
      mismatch_count_o = 0;
      note_results_due.delete();
      results_due_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (note_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_data_i);
          mismatch_count_o++;
        end else begin
          due = note_results_due.pop_front();
          check_field("avg_freq_q4", due.avg, m_data_i[23:0]);
          check_field("nearest_note", due.note, m_data_i[26:24]);
          check_field("in_tolerance", due.in_tol, m_data_i[27]);
          check_field("announce", due.announce, m_data_i[28]);
          check_field("padding", 0, m_data_i[31:29]);
        end
      end
      if (s_valid_i && s_ready_i && s_data_i[PERIOD_W-1:0] != '0) begin
        classify_period(s_data_i[PERIOD_W-1:0], due);
        note_results_due.push_back(due);
      end
      if (cfg_we_i) begin
        tolerance = cfg_wdata_i;
      end
      results_due_o <= note_results_due.size();
    end
  end

endmodule

// ----- test/pitch_note_classifier_test.sv -----
`timescale 1ns / 1ps

module pitch_note_classifier_test import pnc_pkg::*;;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [TOL_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [23:0] period_us
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [23:0] avg, [26:24] note, [27] in_tol, [28] announce

  int send_idle_pct = 22;
  int recv_idle_pct = 57;
  int mismatches;
  int results_due;

  pitch_note_classifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  note_stream_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_i       (s_axis_tready),
    .s_data_i        (s_axis_tdata),
    .m_valid_i       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_i        (m_axis_tdata),
    .mismatch_count_o(mismatches),
    .results_due_o   (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_period(input logic [PERIOD_W-1:0] period);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(period);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [TOL_W-1:0]    tol_plan [6];
    logic [PERIOD_W-1:0] period;
    int                  phase;
    int                  sent;
    int                  kind;
    int                  run_len;
    int                  jit;
    int                  note;
    tol_plan = '{14'd16383, 14'd1, 14'd0, 14'(TOL_W'($urandom_range(1, 16000))),
                 14'd16000, TOL_RST};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tolerance: extremes, a distance tie, held notes
    send_period(0);
    send_period(1);
    send_period('1);
    send_period(0);
    repeat (5) send_period(2946);
    repeat (5) send_period(3822);
    repeat (5) send_period(1911);
    send_period(2);

    for (phase = 0; phase < 6; phase++) begin
      drain_results();
      write_tolerance(tol_plan[phase]);
      if (phase < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 57;
      end else if (phase < 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sent = 0;
      while (sent < 160) begin
        kind = $urandom_range(9);
        if (kind < 7) begin
          note    = $urandom_range(NOTE_CNT - 1);
          run_len = $urandom_range(1, 8);
          jit     = $urandom_range(0, 24);
          repeat (run_len) begin
            period = PERIOD_W'(int'(FREQ_NUM_Q4 / NOTE_Q4[note]) + $urandom_range(0, 2 * jit) - jit);
            send_period(period);
            sent++;
          end
        end else begin
          case (kind)
            7:       period = PERIOD_W'($urandom());
            8:       period = '0;
            default: period = ($urandom_range(1) != 0) ? PERIOD_W'($urandom_range(1, 64)) :
                              PERIOD_W'(FREQ_NUM_Q4 / $urandom_range(3500, 9000));
          endcase
          send_period(period);
          if (period != '0) begin
            sent++;
          end
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pnc_pkg.sv
hw/rtl/pnc_div.sv
hw/rtl/pnc_ring.sv
hw/rtl/pnc_match.sv
hw/rtl/pitch_note_classifier.sv
test/note_stream_checker.sv
test/pitch_note_classifier_test.sv
